@@ rtl/iste_pkg.sv @@
// shared types, codes and helpers of the infix two-stack evaluator
package iste_pkg;

    localparam int DATA_W = 32;
    localparam int NUM_W  = 31;
    localparam int CODE_W = 3;
    localparam int ACT_W  = 2;

    // token kinds
    localparam logic [ACT_W-1:0] ACT_NUM = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END = 2'd2;

    // operator codes
    localparam logic [CODE_W-1:0] OP_ADD   = 3'd0;
    localparam logic [CODE_W-1:0] OP_SUB   = 3'd1;
    localparam logic [CODE_W-1:0] OP_MUL   = 3'd2;
    localparam logic [CODE_W-1:0] OP_DIV   = 3'd3;
    localparam logic [CODE_W-1:0] OP_OPEN  = 3'd4;
    localparam logic [CODE_W-1:0] OP_CLOSE = 3'd5;

    // error flag bit positions
    localparam int FLAG_UNMATCHED = 0;
    localparam int FLAG_DIVZERO   = 1;
    localparam int FLAG_OVERFLOW  = 2;
    localparam int FLAG_W         = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST,
        ST_POP2,
        ST_WAIT1,
        ST_POP1,
        ST_EXEC,
        ST_DIVW,
        ST_PUSH,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic latch_tok;
        logic push_num;
        logic push_op_in;
        logic push_op_tok;
        logic pop_v2;
        logic pop_v1;
        logic exec;
        logic take_quot;
        logic push_res;
        logic close_pop;
        logic set_unmatched;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic              vc_zero;
        logic              oc_zero;
        logic [CODE_W-1:0] top_op;
        logic [CODE_W-1:0] tok_code;
        logic              tok_end;
        logic              need_div;
        logic              div_done;
        logic              out_free;
    } t_stat;

    // whether the reduction loop keeps going for the pending token
    function automatic logic loop_go(input logic is_end, input logic [CODE_W-1:0] code,
                                     input logic [CODE_W-1:0] top);
        logic go;
        go = 1'b0;
        if (is_end) begin
            go = 1'b1;
        end else begin
            case (code)
                OP_ADD, OP_SUB: go = (top == OP_ADD) || (top == OP_SUB) ||
                                     (top == OP_MUL) || (top == OP_DIV);
                OP_MUL, OP_DIV: go = (top == OP_MUL) || (top == OP_DIV);
                OP_CLOSE:       go = (top != OP_OPEN);
                default:        go = 1'b0;
            endcase
        end
        return go;
    endfunction

endpackage

@@ rtl/iste_if.sv @@
// token and result channel interfaces of the evaluator
interface iste_tok_if;
    logic                          valid;
    logic                          ready;
    logic [iste_pkg::ACT_W-1:0]    action;
    logic [iste_pkg::NUM_W-1:0]    number;
    logic [iste_pkg::CODE_W-1:0]   operator_code;

    modport source (output valid, output action, output number, output operator_code,
                    input ready);
    modport sink (input valid, input action, input number, input operator_code,
                  output ready);
endinterface

interface iste_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [iste_pkg::DATA_W-1:0] answer;
    logic                              status;
    logic                              unmatched_close;
    logic                              divide_by_zero;
    logic                              stack_overflow;

    modport source (output valid, output answer, output status, output unmatched_close,
                    output divide_by_zero, output stack_overflow, input ready);
    modport sink (input valid, input answer, input status, input unmatched_close,
                  input divide_by_zero, input stack_overflow, output ready);
endinterface

@@ rtl/iste_div.sv @@
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module iste_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [iste_pkg::DATA_W-1:0] i_dividend,
    input  logic [iste_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [iste_pkg::DATA_W-1:0] o_quot
);
    localparam int DW = iste_pkg::DATA_W;
    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;

    logic [DW:0]   rem_sh;
    logic          fits;
    logic [DW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign fits    = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[DW-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den <= i_divisor[DW-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DW-1] ^ i_divisor[DW-1];
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

@@ rtl/iste_ctrl.sv @@
// sequencer of the evaluator: token decode and reduction loop control
module iste_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [iste_pkg::ACT_W-1:0]    i_action,
    input  logic [iste_pkg::CODE_W-1:0]   i_code,
    input  iste_pkg::t_stat               i_stat,
    output logic                          o_in_ready,
    output iste_pkg::t_cmd                o_cmd
);
    iste_pkg::t_state r_state;
    iste_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iste_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            iste_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_action)
                        iste_pkg::ACT_NUM: begin
                            o_cmd.push_num = 1'b1;
                        end
                        iste_pkg::ACT_OP: begin
                            case (i_code)
                                iste_pkg::OP_OPEN: begin
                                    o_cmd.push_op_in = 1'b1;
                                end
                                iste_pkg::OP_ADD, iste_pkg::OP_SUB, iste_pkg::OP_MUL,
                                iste_pkg::OP_DIV, iste_pkg::OP_CLOSE: begin
                                    o_cmd.latch_tok = 1'b1;
                                    n_state         = iste_pkg::ST_CHECK;
                                end
                                default: begin
                                end
                            endcase
                        end
                        iste_pkg::ACT_END: begin
                            o_cmd.latch_tok = 1'b1;
                            n_state         = iste_pkg::ST_CHECK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            iste_pkg::ST_CHECK: begin
                n_state = iste_pkg::ST_TEST;
            end
            iste_pkg::ST_TEST: begin
                if (!i_stat.oc_zero &&
                    iste_pkg::loop_go(i_stat.tok_end, i_stat.tok_code, i_stat.top_op)) begin
                    n_state = iste_pkg::ST_POP2;
                end else begin
                    n_state = iste_pkg::ST_FINISH;
                end
            end
            iste_pkg::ST_POP2: begin
                if (i_stat.vc_zero) begin
                    n_state = iste_pkg::ST_FINISH;
                end else begin
                    o_cmd.pop_v2 = 1'b1;
                    n_state      = iste_pkg::ST_WAIT1;
                end
            end
            iste_pkg::ST_WAIT1: begin
                n_state = iste_pkg::ST_POP1;
            end
            iste_pkg::ST_POP1: begin
                if (i_stat.vc_zero) begin
                    n_state = iste_pkg::ST_FINISH;
                end else begin
                    o_cmd.pop_v1 = 1'b1;
                    n_state      = iste_pkg::ST_EXEC;
                end
            end
            iste_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_div ? iste_pkg::ST_DIVW : iste_pkg::ST_PUSH;
            end
            iste_pkg::ST_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = iste_pkg::ST_PUSH;
                end
            end
            iste_pkg::ST_PUSH: begin
                o_cmd.push_res = 1'b1;
                n_state        = iste_pkg::ST_CHECK;
            end
            iste_pkg::ST_FINISH: begin
                if (i_stat.tok_end) begin
                    n_state = iste_pkg::ST_EMIT;
                end else begin
                    n_state = iste_pkg::ST_IDLE;
                    if (i_stat.tok_code == iste_pkg::OP_CLOSE) begin
                        if (i_stat.oc_zero) begin
                            o_cmd.set_unmatched = 1'b1;
                        end else begin
                            o_cmd.close_pop = 1'b1;
                        end
                    end else begin
                        o_cmd.push_op_tok = 1'b1;
                    end
                end
            end
            iste_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = iste_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iste_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/iste_datapath.sv @@
// stacks, arithmetic, divider and result register of the evaluator
module iste_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [iste_pkg::NUM_W-1:0]         i_number,
    input  logic [iste_pkg::CODE_W-1:0]        i_code,
    input  logic [iste_pkg::ACT_W-1:0]         i_action,
    input  iste_pkg::t_cmd                     i_cmd,
    output iste_pkg::t_stat                    o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [iste_pkg::DATA_W-1:0] o_answer,
    output logic                               o_status,
    output logic                               o_unmatched_close,
    output logic                               o_divide_by_zero,
    output logic                               o_stack_overflow
);
    localparam int DW = iste_pkg::DATA_W;
    localparam int OW = iste_pkg::CODE_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0] r_val_mem [STACK_DEPTH];
    logic [OW-1:0] r_op_mem  [STACK_DEPTH];

    logic [CW-1:0] r_vc;
    logic [CW-1:0] r_oc;
    logic [DW-1:0] r_top_val;
    logic [OW-1:0] r_top_op;
    logic [DW-1:0] r_v1;
    logic [DW-1:0] r_v2;
    logic [DW-1:0] r_res;
    logic [OW-1:0] r_code;
    logic          r_is_end;
    logic [iste_pkg::FLAG_W-1:0] r_flags;

    logic          r_out_valid;
    logic [DW-1:0] r_answer;
    logic          r_status;
    logic [iste_pkg::FLAG_W-1:0] r_out_flags;

    logic          vc_full;
    logic          oc_full;
    logic [CW-1:0] vc_dec;
    logic [CW-1:0] oc_dec;
    logic          val_push;
    logic [DW-1:0] val_wdata;
    logic          op_push;
    logic [OW-1:0] op_wdata;
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic          v2_zero;

    assign vc_full   = (r_vc == CW'(STACK_DEPTH));
    assign oc_full   = (r_oc == CW'(STACK_DEPTH));
    assign vc_dec    = r_vc - 1'b1;
    assign oc_dec    = r_oc - 1'b1;
    assign val_push  = i_cmd.push_num || i_cmd.push_res;
    assign val_wdata = i_cmd.push_num ? {1'b0, i_number} : r_res;
    assign op_push   = i_cmd.push_op_in || i_cmd.push_op_tok;
    assign op_wdata  = i_cmd.push_op_in ? i_code : r_code;
    assign v2_zero   = (r_v2 == '0);
    assign div_start = i_cmd.exec && (r_top_op == iste_pkg::OP_DIV) && !v2_zero;

    // stack memories, registered read of the current top entries
    always_ff @(posedge i_clk) begin
        if (val_push && !vc_full) begin
            r_val_mem[r_vc[AW-1:0]] <= val_wdata;
        end
        r_top_val <= r_val_mem[vc_dec[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (op_push && !oc_full) begin
            r_op_mem[r_oc[AW-1:0]] <= op_wdata;
        end
        r_top_op <= r_op_mem[oc_dec[AW-1:0]];
    end

    // counters, flags and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= '0;
            r_oc        <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (val_push) begin
                if (vc_full) begin
                    r_flags[iste_pkg::FLAG_OVERFLOW] <= 1'b1;
                end else begin
                    r_vc <= r_vc + 1'b1;
                end
            end
            if (op_push) begin
                if (oc_full) begin
                    r_flags[iste_pkg::FLAG_OVERFLOW] <= 1'b1;
                end else begin
                    r_oc <= r_oc + 1'b1;
                end
            end
            if (i_cmd.pop_v2 || i_cmd.pop_v1) begin
                r_vc <= vc_dec;
            end
            if (i_cmd.push_res || i_cmd.close_pop) begin
                r_oc <= oc_dec;
            end
            if (i_cmd.set_unmatched) begin
                r_flags[iste_pkg::FLAG_UNMATCHED] <= 1'b1;
            end
            if (i_cmd.exec && (r_top_op == iste_pkg::OP_DIV) && v2_zero) begin
                r_flags[iste_pkg::FLAG_DIVZERO] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_vc        <= '0;
                r_oc        <= '0;
                r_flags     <= '0;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_tok) begin
            r_code   <= i_code;
            r_is_end <= (i_action == iste_pkg::ACT_END);
        end
        if (i_cmd.pop_v2) begin
            r_v2 <= r_top_val;
        end
        if (i_cmd.pop_v1) begin
            r_v1 <= r_top_val;
        end
        if (i_cmd.exec) begin
            case (r_top_op)
                iste_pkg::OP_ADD: r_res <= r_v1 + r_v2;
                iste_pkg::OP_SUB: r_res <= r_v1 - r_v2;
                iste_pkg::OP_MUL: r_res <= r_v1 * r_v2;
                default:          r_res <= '0;
            endcase
        end else if (i_cmd.take_quot) begin
            r_res <= div_quot;
        end
        if (i_cmd.emit) begin
            r_answer    <= (r_vc == '0) ? '0 : r_top_val;
            r_status    <= (r_vc == '0);
            r_out_flags <= r_flags;
        end
    end

    iste_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_v1),
        .i_divisor  (r_v2),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        o_stat          = '0;
        o_stat.vc_zero  = (r_vc == '0);
        o_stat.oc_zero  = (r_oc == '0);
        o_stat.top_op   = r_top_op;
        o_stat.tok_code = r_code;
        o_stat.tok_end  = r_is_end;
        o_stat.need_div = (r_top_op == iste_pkg::OP_DIV) && !v2_zero;
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_answer          = r_answer;
    assign o_status          = r_status;
    assign o_unmatched_close = r_out_flags[iste_pkg::FLAG_UNMATCHED];
    assign o_divide_by_zero  = r_out_flags[iste_pkg::FLAG_DIVZERO];
    assign o_stack_overflow  = r_out_flags[iste_pkg::FLAG_OVERFLOW];

endmodule

@@ rtl/infix_two_stack_evaluator.sv @@
// top level of the two-stack infix expression evaluator
// Evaluates an infix expression given one token per transfer on i_tok: a non-negative
// number, an operator (+ - * / and parentheses) or an end mark. Numbers and open
// parentheses are pushed in the cycle they are taken, so a run of them goes at one token
// per cycle. Any other operator runs the reduction loop for each reduction it
// triggers, and a division waits for the quotient from a shared radix-2 divider at
// one bit per cycle. The end mark also runs its reductions, and waits while an
// earlier result still sits on o_res. Both stacks are memories with one write port
// and a registered read port, so the sequencer passes a wait state (ST_WAIT1 or
// ST_CHECK) between a pop and the use of the new top. The end mark reduces
// everything left and loads one result into the output register (answer, empty-stack
// status and the sticky error flags of the expression), then clears the stacks and flags
// for the next expression; the next token can be taken while that result still waits on
// o_res. Arithmetic wraps at 32 bits, a zero divisor gives 0 and a flag, and a push to a
// full stack is dropped and flagged. No clearing pass is needed after reset.
module infix_two_stack_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iste_tok_if.sink      i_tok,
    iste_res_if.source    o_res
);
    // command and status bundles between sequencer and datapath
    iste_pkg::t_cmd  cmd;
    iste_pkg::t_stat stat;
    logic            in_ready;

    // the sequencer owns the input handshake and steps the reduction loop
    iste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .i_action   (i_tok.action),
        .i_code     (i_tok.operator_code),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_tok.ready = in_ready;

    // stacks, arithmetic and the result register that parts the output side
    iste_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_number          (i_tok.number),
        .i_code            (i_tok.operator_code),
        .i_action          (i_tok.action),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_answer          (o_res.answer),
        .o_status          (o_res.status),
        .o_unmatched_close (o_res.unmatched_close),
        .o_divide_by_zero  (o_res.divide_by_zero),
        .o_stack_overflow  (o_res.stack_overflow)
    );

endmodule
